// ----- rtl/dsfb_pkg.sv -----
// ----------------------------------------------------------------------------
// dsfb_pkg
// Shared widths, defaults and tables for the depth stack fusion block.
// ----------------------------------------------------------------------------
package dsfb_pkg;

    localparam int PIX_W   = 19;
    localparam int FRM_W   = 4;
    localparam int RAW_W   = 16;
    localparam int FCNT_W  = 5;
    localparam int SCALE_W = 21;
    localparam int D_W     = 21;
    localparam int DSQ_W   = 42;
    localparam int ZC_W    = 5;
    localparam int SUM_W   = 25;
    localparam int SQ_W    = 45;
    localparam int ENTRY_W = ZC_W + SUM_W + SQ_W;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 8;
    localparam int PROD_W  = 50;
    localparam int NN_W    = 9;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;
    localparam int DEF_MAX_FRAMES   = 16;

    localparam logic [FCNT_W-1:0]  FCNT_RESET  = 5'd4;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 21'd20480;

    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_SCALE       = 1'b1;

    // zero-sample penalty per frame count: floor(255/F)
    localparam logic [7:0] PEN_STEP [0:16] = '{
        8'd255, 8'd255, 8'd127, 8'd85, 8'd63, 8'd51, 8'd42, 8'd36, 8'd31,
        8'd28, 8'd25, 8'd23, 8'd21, 8'd19, 8'd18, 8'd17, 8'd15
    };

endpackage

// ----- rtl/dsfb_ram.sv -----
// ----------------------------------------------------------------------------
// dsfb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsfb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dsfb_div.sv -----
// ----------------------------------------------------------------------------
// dsfb_div
// Restoring divider, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module dsfb_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_bit;

    always_comb begin
        w_trial = {r_rem, r_quot[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_bit   = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], w_bit};
            r_rem  <= w_bit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/depth_stack_fusion_belief.sv -----
// Non-final frames: an accepted word passes S_MUL, S_SQ and S_UPD (write-back), then S_IDLE.
// Final frame: S_PREP, then up to two 50-step divisions (mean, variance) on one shared divider,
// then S_BEL registers the result; the next word is taken after S_BEL. One in flight.
// Stores come from one 75-bit RAM, read-modify-write, with registered read data.
// Reset (synchronous, active low) restores the configuration registers and control only;
// per-pixel stores hold garbage until a pixel's frame 0 is seen.
// ----------------------------------------------------------------------------
// depth_stack_fusion_belief
// Per-pixel temporal depth fusion: mean, variance and belief per stack.
// ----------------------------------------------------------------------------
module depth_stack_fusion_belief #(
    parameter int FRAME_WIDTH  = dsfb_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = dsfb_pkg::DEF_FRAME_HEIGHT,
    parameter int MAX_FRAMES   = dsfb_pkg::DEF_MAX_FRAMES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [dsfb_pkg::SCALE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dsfb_pkg::PIX_W-1:0]    i_pixel_index,
    input  logic [dsfb_pkg::FRM_W-1:0]    i_frame_index,
    input  logic [dsfb_pkg::RAW_W-1:0]    i_depth_raw,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dsfb_pkg::PIX_W-1:0]    o_out_pixel,
    output logic [dsfb_pkg::MEAN_W-1:0]   o_mean_depth,
    output logic [dsfb_pkg::VAR_W-1:0]    o_variance,
    output logic [dsfb_pkg::VAR_W-1:0]    o_belief,
    output logic                          o_no_data
);

    localparam int PIXELS    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_FULL = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int ADDR_W    = (ADDR_FULL > dsfb_pkg::PIX_W) ? dsfb_pkg::PIX_W : ADDR_FULL;
    localparam int RAM_DEPTH = (PIXELS > (2 ** ADDR_W)) ? (2 ** ADDR_W) : PIXELS;
    localparam int F_LIM     = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
    localparam logic [dsfb_pkg::FCNT_W-1:0] F_LIM_V = dsfb_pkg::FCNT_W'(F_LIM);
    localparam logic [31:0] PIXELS_V = 32'(PIXELS);
    localparam int ZC_W   = dsfb_pkg::ZC_W;
    localparam int SUM_W  = dsfb_pkg::SUM_W;
    localparam int SQ_W   = dsfb_pkg::SQ_W;
    localparam int PROD_W = dsfb_pkg::PROD_W;
    localparam int NN_W   = dsfb_pkg::NN_W;
    localparam int FW     = dsfb_pkg::FCNT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_UPD  = 8'b0000_1000,
        S_PREP = 8'b0001_0000,
        S_MEAN = 8'b0010_0000,
        S_VARD = 8'b0100_0000,
        S_BEL  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [FW-1:0]                 r_frame_count;
    logic [dsfb_pkg::SCALE_W-1:0]  r_scale;
    logic [dsfb_pkg::PIX_W-1:0]    r_pix;
    logic                          r_clr;
    logic                          r_emit;
    logic [dsfb_pkg::RAW_W-1:0]    r_raw;
    logic [dsfb_pkg::D_W-1:0]      r_d;
    logic [dsfb_pkg::DSQ_W-1:0]    r_dsq;
    logic [ZC_W-1:0]               r_zc;
    logic [SUM_W-1:0]              r_sum;
    logic [SQ_W-1:0]               r_sq;
    logic [FW-1:0]                 r_n;
    logic [PROD_W-1:0]             r_a;
    logic [PROD_W-1:0]             r_b;
    logic [dsfb_pkg::MEAN_W-1:0]   r_mean;
    logic [dsfb_pkg::VAR_W-1:0]    r_var;
    logic                          r_out_valid;
    logic [dsfb_pkg::PIX_W-1:0]    r_out_pixel;
    logic [dsfb_pkg::MEAN_W-1:0]   r_out_mean;
    logic [dsfb_pkg::VAR_W-1:0]    r_out_var;
    logic [dsfb_pkg::VAR_W-1:0]    r_out_bel;
    logic                          r_out_none;

    logic [FW-1:0]                 w_f;
    logic [FW-1:0]                 w_flast;
    logic                          w_accept;
    logic                          w_take;
    logic [36:0]                   w_prod;
    logic [dsfb_pkg::ENTRY_W-1:0]  w_rdata;
    logic [dsfb_pkg::ENTRY_W-1:0]  w_wdata;
    logic                          w_we;
    logic [ZC_W-1:0]               w_old_zc;
    logic [SUM_W-1:0]              w_old_sum;
    logic [SQ_W-1:0]               w_old_sq;
    logic [SUM_W:0]                w_sum_ext;
    logic [SQ_W:0]                 w_sq_ext;
    logic [ZC_W-1:0]               n_zc;
    logic [SUM_W-1:0]              n_sum;
    logic [SQ_W-1:0]               n_sq;
    logic [FW-1:0]                 w_n;
    logic                          w_var_go;
    logic                          w_div_start;
    logic [PROD_W-1:0]             w_div_num;
    logic [NN_W-1:0]               w_div_den;
    logic                          w_div_busy;
    logic                          w_div_done;
    logic [PROD_W-1:0]             w_div_quot;
    logic [13:0]                   w_pen;
    logic [dsfb_pkg::VAR_W-1:0]    w_bel;

    // effective frame count, clamped to 1..min(MAX_FRAMES,16)
    always_comb begin
        if (r_frame_count == '0) begin
            w_f = FW'(1);
        end else if (r_frame_count > F_LIM_V) begin
            w_f = F_LIM_V;
        end else begin
            w_f = r_frame_count;
        end
        w_flast = w_f - FW'(1);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = w_accept && ({13'b0, i_pixel_index} < PIXELS_V)
                        && ({1'b0, i_frame_index} <= w_flast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= dsfb_pkg::FCNT_RESET;
            r_scale       <= dsfb_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dsfb_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FW-1:0];
                dsfb_pkg::CFG_SCALE:       r_scale       <= i_cfg_data;
                default:                   r_scale       <= r_scale;
            endcase
        end
    end

    assign w_prod = {21'b0, r_raw} * {16'b0, r_scale};

    dsfb_ram #(
        .WIDTH  (dsfb_pkg::ENTRY_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pix[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_pix[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // frame zero starts from a clean entry
    always_comb begin
        w_old_zc  = r_clr ? '0 : w_rdata[dsfb_pkg::ENTRY_W-1 -: ZC_W];
        w_old_sum = r_clr ? '0 : w_rdata[SQ_W +: SUM_W];
        w_old_sq  = r_clr ? '0 : w_rdata[SQ_W-1:0];
        w_sum_ext = {1'b0, w_old_sum} + {5'b0, r_d};
        w_sq_ext  = {1'b0, w_old_sq} + {4'b0, r_dsq};
        n_zc  = w_old_zc;
        n_sum = w_old_sum;
        n_sq  = w_old_sq;
        if (r_d == '0) begin
            if (w_old_zc != {ZC_W{1'b1}}) begin
                n_zc = w_old_zc + ZC_W'(1);
            end
        end else begin
            n_sum = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];
            n_sq  = w_sq_ext[SQ_W] ? {SQ_W{1'b1}} : w_sq_ext[SQ_W-1:0];
        end
        w_we    = (r_state == S_UPD);
        w_wdata = {n_zc, n_sum, n_sq};
    end

    assign w_n = ({1'b0, r_zc} >= {1'b0, w_f}) ? '0 : (w_f - r_zc);

    // share the divider: mean first, variance after
    always_comb begin
        w_var_go = (r_n > FW'(1)) && (r_a > r_b);
        if (r_state == S_PREP) begin
            w_div_num   = {{(PROD_W - SUM_W - 4){1'b0}}, r_sum, 4'b0};
            w_div_den   = {{(NN_W - FW){1'b0}}, w_n};
            w_div_start = (w_n != '0);
        end else begin
            w_div_num   = r_a - r_b;
            w_div_den   = NN_W'(r_n) * NN_W'(r_n);
            w_div_start = (r_state == S_MEAN) && w_div_done && w_var_go;
        end
    end

    dsfb_div #(
        .NUM_W (PROD_W),
        .DEN_W (NN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        w_pen = 14'(r_zc) * 14'(dsfb_pkg::PEN_STEP[w_f]) + 14'(r_var);
        w_bel = (w_pen >= 14'd255) ? '0 : (8'd255 - w_pen[7:0]);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take) n_state = S_MUL;
            S_MUL:  n_state = S_SQ;
            S_SQ:   n_state = S_UPD;
            S_UPD:  n_state = r_emit ? S_PREP : S_IDLE;
            S_PREP: n_state = (w_n == '0) ? S_BEL : S_MEAN;
            S_MEAN: begin
                if (w_div_done) begin
                    n_state = w_var_go ? S_VARD : S_BEL;
                end
            end
            S_VARD: if (w_div_done) n_state = S_BEL;
            S_BEL:  if (!r_out_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_BEL && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pix  <= i_pixel_index;
            r_raw  <= i_depth_raw;
            r_clr  <= (i_frame_index == '0);
            r_emit <= ({1'b0, i_frame_index} == w_flast);
        end
        if (r_state == S_MUL) begin
            r_d <= w_prod[36:16];
        end
        if (r_state == S_SQ) begin
            r_dsq <= r_d * r_d;
        end
        if (r_state == S_UPD) begin
            r_zc  <= n_zc;
            r_sum <= n_sum;
            r_sq  <= n_sq;
        end
        if (r_state == S_PREP) begin
            r_n <= w_n;
            r_a <= PROD_W'(w_n) * PROD_W'(r_sq);
            r_b <= r_sum * r_sum;
            if (w_n == '0) begin
                r_mean <= '0;
                r_var  <= '0;
            end
        end
        if (r_state == S_MEAN && w_div_done) begin
            r_mean <= (w_div_quot > PROD_W'({dsfb_pkg::MEAN_W{1'b1}}))
                      ? {dsfb_pkg::MEAN_W{1'b1}} : w_div_quot[dsfb_pkg::MEAN_W-1:0];
            if (!w_var_go) begin
                r_var <= '0;
            end
        end
        if (r_state == S_VARD && w_div_done) begin
            r_var <= (w_div_quot > PROD_W'(255)) ? 8'd255 : w_div_quot[7:0];
        end
        if (r_state == S_BEL && !r_out_valid) begin
            r_out_pixel <= r_pix;
            r_out_mean  <= r_mean;
            r_out_var   <= r_var;
            r_out_bel   <= w_bel;
            r_out_none  <= (r_n == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_pixel  = r_out_pixel;
    assign o_mean_depth = r_out_mean;
    assign o_variance   = r_out_var;
    assign o_belief     = r_out_bel;
    assign o_no_data    = r_out_none;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_data) |-> (o_mean_depth == '0 && o_variance == '0))
        else $error("no-data result with nonzero mean or variance");

    a_belief_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_belief} + {1'b0, o_variance} <= 9'd255))
        else $error("belief plus variance above 255");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !o_in_ready)
        else $error("second word taken while one is in flight");
`endif

endmodule
